### src/ptpd_pkg.sv
// shared types and constants for the perspective-divide point transform
// no dependencies
`default_nettype none
package ptpd_pkg;
	localparam int unsigned ELEMS      = 16;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned DATA_W     = 32;
	localparam logic        REQ_LOAD   = 1'b0;
	localparam logic        REQ_XFORM  = 1'b1;
endpackage
`default_nettype wire

### src/ptpd_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module ptpd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/point_transform_perspective_divide.sv
// top level of the 4x4 homogeneous point transform with perspective divide
// depends on ptpd_pkg and ptpd_ram
`default_nettype none
// usage
//   s_axis carries one request per beat: tuser is the request kind
//   (0 load element, 1 transform point). a load beat writes one matrix
//   element and gives no result; a transform beat gives one result beat
//   on m_axis with the divided coordinates and the two flags.
//   the matrix sits in a 16 x 32 ram; reset clears per-entry valid bits,
//   and an entry not yet written reads as the identity value.
// operation and rate
//   loads can follow back to back. a transform reads the 16 elements
//   one a cycle through the ram read port, w row first, through one
//   shared 32x32 multiplier and accumulator, then three restoring
//   divides of 64 quotient bits, one row at a time. no new beat is taken
//   until the result is in the output register. with zero w the divides
//   are skipped.
// stalls
//   the result waits in an output register; the next request is taken
//   while it waits, and the block stalls only when a new result is ready
//   and the previous one has not been taken.
module point_transform_perspective_divide
	import ptpd_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,  // elem_index, elem_value, point_x, point_y, point_z
	input  wire logic         s_axis_tuser,  // req_type
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [103:0]      m_axis_tdata,  // out_x, out_y, out_z, divide_by_zero, overflow
	output logic              m_axis_tuser   // unused, zero
);
	localparam int CW = 7;
	localparam logic [CW-1:0] DIV_STEPS = CW'(64);  // quotient bits per row
	localparam logic [CW-1:0] DIV_LAST  = CW'(65);  // row result taken here
	localparam logic signed [31:0] ONE_Q = 32'(64'sd1 <<< FRAC_BITS);
	// read order: w row first (12..15) then rows 0..2, ending at 11
	localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(12);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(11);

	localparam logic [1:0] ST_IDLE = 2'd0, ST_MAC = 2'd1, ST_DIV = 2'd2,
		ST_OUT = 2'd3;

	logic [1:0]         st_q;
	logic [ELEMS-1:0]   valid_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [IDX_W:0]     rd_q;      // element reads issued, 0..16
	logic               rd_v_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic signed [63:0] prod_s2;
	logic               prod_v_s2;
	logic [IDX_W-1:0]   prod_idx_s2;
	logic signed [63:0] acc_q;
	logic signed [63:0] nr_q [4];  // row sums, entry 3 is w
	logic [1:0]         row_q;
	logic [CW-1:0]      cnt_q;
	logic [63:0]        aw_q, rem_q, dvd_q;
	logic               neg_q, sat_q, dz_q;
	logic [95:0]        res_q;     // z, y, x shifted in from the top
	logic               out_v_q, out_dz_q, out_ov_q;
	logic [95:0]        out_d_q;

	logic             ram_we;
	logic [31:0]      ram_rd;
	logic [IDX_W-1:0] ram_raddr;
	logic             load_acc, xform_acc, mac_issue, out_free;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign load_acc  = s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_LOAD;
	assign xform_acc = s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_XFORM;
	assign mac_issue = (st_q == ST_MAC) && !rd_q[IDX_W];
	assign out_free  = !out_v_q || m_axis_tready;
	assign ram_we    = load_acc;
	assign ram_raddr = rd_q[IDX_W-1:0] + FIRST_IDX;

	ptpd_ram #(.WIDTH(DATA_W), .DEPTH(ELEMS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(s_axis_tdata[3:0]),
		.wdata(s_axis_tdata[35:4]), .raddr(ram_raddr), .rdata(ram_rd)
	);

	// element value with identity fallback for entries not yet written
	logic signed [31:0] elem;
	always_comb begin
		if (valid_q[rd_idx_s1]) elem = ram_rd;
		else if (rd_idx_s1[1:0] == rd_idx_s1[3:2]) elem = ONE_Q;
		else elem = '0;
	end

	logic signed [31:0] coord;
	always_comb begin
		case (rd_idx_s1[1:0])
			2'd0:    coord = px_q;
			2'd1:    coord = py_q;
			2'd2:    coord = pz_q;
			default: coord = '0;
		endcase
	end

	// product floored to the fraction width; the last column adds as it is
	logic signed [63:0] mul_full, term, acc_sum;
	always_comb begin
		mul_full = elem * coord;
		term = (rd_idx_s1[1:0] == 2'd3) ? 64'(elem) : (mul_full >>> FRAC_BITS);
		acc_sum = ((prod_idx_s2[1:0] == 2'd0) ? 64'sd0 : acc_q) + prod_s2;
	end

	// restoring divide of |n| << FRAC_BITS by |w|, quotient shifts into dvd_q
	logic signed [63:0] nsel, w_sum;
	logic [63:0] an, aw;
	logic [64:0] rem_sh, rem_sub;
	logic        rem_ge, q_sat;
	logic [31:0] q_res;
	always_comb begin
		nsel = nr_q[row_q];
		w_sum = nr_q[3];
		an = nsel[63] ? 64'(-nsel) : 64'(nsel);
		aw = w_sum[63] ? 64'(-w_sum) : 64'(w_sum);
		rem_sh = {rem_q, dvd_q[63]};
		rem_sub = rem_sh - {1'b0, aw_q};
		rem_ge = (rem_sh >= {1'b0, aw_q});
		q_sat = neg_q ? (dvd_q > 64'h0000_0000_8000_0000) :
			(dvd_q > 64'h0000_0000_7fff_ffff);
		q_res = q_sat ? (neg_q ? 32'h8000_0000 : 32'h7fff_ffff) :
			(neg_q ? (~dvd_q[31:0]) + 32'd1 : dvd_q[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			valid_q <= '0;
			rd_q <= '0;
			rd_v_s1 <= 1'b0;
			prod_v_s2 <= 1'b0;
			row_q <= '0;
			cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= mac_issue;
			prod_v_s2 <= rd_v_s1;
			if (load_acc) valid_q[s_axis_tdata[3:0]] <= 1'b1;
			if (st_q == ST_OUT && out_free) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (xform_acc) begin
						rd_q <= '0;
						st_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (mac_issue) rd_q <= rd_q + (IDX_W+1)'(1);
					if (prod_v_s2 && prod_idx_s2 == LAST_IDX) begin
						row_q <= '0;
						cnt_q <= '0;
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (w_sum == 64'sd0) begin
						st_q <= ST_OUT;
					end else if (cnt_q == DIV_LAST) begin
						cnt_q <= '0;
						if (row_q == 2'd2) st_q <= ST_OUT;
						else row_q <= row_q + 2'd1;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_OUT: begin
					if (out_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers without reset: point, multiplier stages, accumulator, divider, output
	always_ff @(posedge clk) begin
		if (xform_acc) begin
			px_q <= s_axis_tdata[67:36];
			py_q <= s_axis_tdata[99:68];
			pz_q <= s_axis_tdata[131:100];
		end
		if (mac_issue) rd_idx_s1 <= ram_raddr;
		if (rd_v_s1) begin
			prod_s2 <= term;
			prod_idx_s2 <= rd_idx_s1;
		end
		if (prod_v_s2) begin
			acc_q <= acc_sum;
			if (prod_idx_s2[1:0] == 2'd3) nr_q[prod_idx_s2[3:2]] <= acc_sum;
		end
		if (st_q == ST_MAC) sat_q <= 1'b0;
		if (st_q == ST_DIV) begin
			dz_q <= (w_sum == 64'sd0);
			if (cnt_q == '0) begin
				aw_q <= aw;
				neg_q <= nsel[63] ^ w_sum[63];
				rem_q <= '0;
				dvd_q <= an << FRAC_BITS;
			end else if (cnt_q <= DIV_STEPS) begin
				rem_q <= rem_ge ? rem_sub[63:0] : rem_sh[63:0];
				dvd_q <= {dvd_q[62:0], rem_ge};
			end else begin
				res_q <= {q_res, res_q[95:32]};
				sat_q <= sat_q | q_sat;
			end
		end
		if (st_q == ST_OUT && out_free) begin
			out_d_q <= dz_q ? '0 : res_q;
			out_dz_q <= dz_q;
			out_ov_q <= sat_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {6'd0, out_ov_q, out_dz_q, out_d_q};
	assign m_axis_tuser  = 1'b0;

	logic unused;
	assign unused = ^{s_axis_tdata[135:132]};
endmodule
`default_nettype wire
